FILE: rtl/asum_pkg.sv
// ----------------------------------------------------------------------------
// asum_pkg
// Shared types and constants for the atanh series summation block.
// ----------------------------------------------------------------------------
package asum_pkg;

	localparam int FRAC_BITS = 30;
	localparam int X_W       = 31;
	localparam int EPS_W     = 31;
	localparam int SUM_W     = 40;
	localparam int CNT_W     = 13;
	localparam int MAG_W     = FRAC_BITS;
	localparam int DIV_STEPS = FRAC_BITS;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1074);
	localparam logic [EPS_W-1:0] ONE_FX    = EPS_W'(1) << FRAC_BITS;
	localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_ACC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic mul;
		logic prep;
		logic div_step;
		logic acc;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic oor;
		logic more;
	} status_t;

endpackage

FILE: rtl/atanh_series_sum.sv
// ----------------------------------------------------------------------------
// atanh_series_sum
// Sums x + x^3/3 + x^5/5 + ... in fixed point until a term drops below eps
// or MAX_TERMS terms are summed; an out-of-range x gives a zero result.
// Each term is one multiply, one scaling multiply, 30 restoring-divide steps
// and one accumulate.
// A new start is taken only while idle, which includes while done shows.
// Reset: arst_n clears the sequencer and loads the tolerance register with 1074.
// ----------------------------------------------------------------------------
module atanh_series_sum #(
	parameter int MAX_TERMS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [asum_pkg::X_W-1:0]   x_value,
	input  logic                              cfg_we,
	input  logic [asum_pkg::EPS_W-1:0]        eps_tolerance,
	output logic                              done,
	output logic signed [asum_pkg::SUM_W-1:0] sum_value,
	output logic [asum_pkg::CNT_W-1:0]        term_count,
	output logic                              out_of_range,
	output logic                              limit_hit
);
	import asum_pkg::*;

	cmd_t    cmd;
	status_t status;

	asum_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	asum_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.eps_tolerance (eps_tolerance),
		.x_value       (x_value),
		.sum_value     (sum_value),
		.term_count    (term_count),
		.out_of_range  (out_of_range),
		.limit_hit     (limit_hit)
	);

endmodule

FILE: rtl/asum_ctrl.sv
// ----------------------------------------------------------------------------
// asum_ctrl
// Sequencer: square, per term multiply, prep, divide, accumulate, then finish.
// ----------------------------------------------------------------------------
module asum_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  asum_pkg::status_t status,
	output asum_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done
);
	import asum_pkg::*;

	state_t              state_q;
	state_t              state_nxt;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic                done_q;
	logic                div_last;

	assign div_last = (div_cnt_q == DCNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_nxt = ST_SQR;
			ST_SQR:  state_nxt = status.oor ? ST_FIN : ST_MUL;
			ST_MUL:  state_nxt = ST_PREP;
			ST_PREP: state_nxt = ST_DIV;
			ST_DIV:  if (div_last) state_nxt = ST_ACC;
			ST_ACC:  state_nxt = status.more ? ST_MUL : ST_FIN;
			ST_FIN:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load     = start;
			ST_SQR:  cmd.square   = 1'b1;
			ST_MUL:  cmd.mul      = 1'b1;
			ST_PREP: cmd.prep     = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_ACC:  cmd.acc      = 1'b1;
			ST_FIN:  cmd.finish   = 1'b1;
			default: cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == ST_FIN);
			if (state_q == ST_PREP) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

`ifndef NO_ASSERTIONS
	a_div_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q < DCNT_W'(DIV_STEPS)))
		else $error("divide step counter out of range");
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> done_q && (state_q == ST_IDLE))
		else $error("finish did not produce a result strobe");
`endif

endmodule

FILE: rtl/asum_dp.sv
// ----------------------------------------------------------------------------
// asum_dp
// Datapath: magnitude, x^2, term recurrence with restoring divider, sum.
// ----------------------------------------------------------------------------
module asum_dp #(
	parameter int MAX_TERMS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  asum_pkg::cmd_t                 cmd,
	output asum_pkg::status_t              status,
	input  logic                           cfg_we,
	input  logic [asum_pkg::EPS_W-1:0]     eps_tolerance,
	input  logic signed [asum_pkg::X_W-1:0] x_value,
	output logic signed [asum_pkg::SUM_W-1:0] sum_value,
	output logic [asum_pkg::CNT_W-1:0]     term_count,
	output logic                           out_of_range,
	output logic                           limit_hit
);
	import asum_pkg::*;

	localparam int NW   = $clog2(MAX_TERMS + 1);
	localparam int DIVW = NW + 1;
	localparam int PW   = MAG_W + DIVW;
	localparam int SW   = FRAC_BITS + NW + 1;
	localparam int EXTW = (SW > SUM_W) ? SW : SUM_W + 1;
	localparam int CW   = (NW > CNT_W) ? NW : CNT_W;

	localparam logic [EXTW-1:0] POS_MAX = EXTW'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic [EXTW-1:0] NEG_MAX = EXTW'({1'b1, {(SUM_W-1){1'b0}}});

	logic [EPS_W-1:0]  eps_q;
	logic [X_W-1:0]    mag_q;
	logic              neg_q;
	logic              oor_q;
	logic [MAG_W-1:0]  x2_q;
	logic [MAG_W-1:0]  a_q;
	logic [MAG_W-1:0]  t_q;
	logic [SW-1:0]     s_q;
	logic [NW-1:0]     n_q;
	logic [DIVW-1:0]   rem_q;
	logic [MAG_W-1:0]  quo_q;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              oor_out_q;
	logic              lim_q;

	logic [2*MAG_W-1:0] sq_prod;
	logic [2*MAG_W-1:0] t_prod;
	logic [PW-1:0]      d_prod;
	logic [DIVW-1:0]    odd_lo;
	logic [DIVW-1:0]    odd_hi;
	logic [DIVW:0]      rem_sh;
	logic               q_bit;
	logic               oor_now;
	logic [EXTW-1:0]    s_ext;
	logic [EXTW-1:0]    s_sat;
	logic [CW-1:0]      n_ext;
	logic [X_W-1:0]     x_mag;

	assign x_mag   = x_value[X_W-1] ? (~x_value + X_W'(1)) : x_value;
	assign sq_prod = mag_q[MAG_W-1:0] * mag_q[MAG_W-1:0];
	assign t_prod  = a_q * x2_q;
	assign odd_lo  = {n_q, 1'b0} - DIVW'(1);
	assign odd_hi  = {n_q, 1'b1};
	assign d_prod  = PW'(t_q) * PW'(odd_lo);
	assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, odd_hi});
	assign oor_now = (eps_q > ONE_FX) || (mag_q >= (ONE_FX - eps_q));

	assign status.oor  = oor_now;
	assign status.more = ({1'b0, quo_q} >= eps_q) && (n_q < NW'(MAX_TERMS));

	always_comb begin
		s_ext = EXTW'(s_q);
		n_ext = CW'(n_q);
		if (neg_q) begin
			s_sat = (s_ext > NEG_MAX) ? NEG_MAX : s_ext;
		end else begin
			s_sat = (s_ext > POS_MAX) ? POS_MAX : s_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= eps_tolerance;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= x_mag;
			neg_q <= x_value[X_W-1];
		end
		if (cmd.square) begin
			oor_q <= oor_now;
			x2_q  <= sq_prod[2*MAG_W-1:FRAC_BITS];
			a_q   <= mag_q[MAG_W-1:0];
			s_q   <= SW'(mag_q[MAG_W-1:0]);
			n_q   <= '0;
		end
		if (cmd.mul) begin
			t_q <= t_prod[2*MAG_W-1:FRAC_BITS];
			n_q <= n_q + NW'(1);
		end
		if (cmd.prep) begin
			rem_q <= d_prod[PW-1:MAG_W];
			quo_q <= d_prod[MAG_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? DIVW'(rem_sh - {1'b0, odd_hi}) : rem_sh[DIVW-1:0];
			quo_q <= {quo_q[MAG_W-2:0], q_bit};
		end
		if (cmd.acc) begin
			a_q <= quo_q;
			s_q <= s_q + SW'(quo_q);
		end
		if (cmd.finish) begin
			if (oor_q) begin
				sum_q     <= '0;
				cnt_q     <= '0;
				oor_out_q <= 1'b1;
				lim_q     <= 1'b0;
			end else begin
				sum_q     <= neg_q ? SUM_W'(~s_sat + EXTW'(1)) : SUM_W'(s_sat);
				cnt_q     <= (n_ext > CW'(CNT_SAT)) ? CNT_SAT : CNT_W'(n_ext);
				oor_out_q <= 1'b0;
				lim_q     <= ({1'b0, a_q} >= eps_q);
			end
		end
	end

	assign sum_value    = sum_q;
	assign term_count   = cnt_q;
	assign out_of_range = oor_out_q;
	assign limit_hit    = lim_q;

`ifndef NO_ASSERTIONS
	a_term_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |=> (a_q <= $past(a_q)))
		else $error("series term grew");
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && oor_q) |=> (sum_q == '0) && (cnt_q == '0) && oor_out_q && !lim_q)
		else $error("out-of-range result not cleared");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && !oor_q) |=> (cnt_q != '0) && !oor_out_q)
		else $error("in-range result with zero term count");
`endif

endmodule
